// ===== rtl/rfaf_pkg.sv =====
// Package for the register file ADD unit with condition codes.
// Holds widths, opcode codes, flag positions and the decoded operation type.
// Used by the channel interfaces and by every RTL module of the block.
`default_nettype none

package rfaf_pkg;

   localparam int unsigned REG_COUNT   = 8;
   localparam int unsigned REG_IDX_W   = 3;
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned OPCODE_W    = 16;
   localparam int unsigned CCR_W       = 8;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;
   localparam logic [1:0] SIZE_LONG = 2'd2;

   localparam logic [7:0] OP_ADD_B_REG = 8'h08;
   localparam logic [7:0] OP_ADD_W_REG = 8'h09;
   localparam logic [7:0] OP_ADD_L_REG = 8'h0A;
   localparam logic [7:0] OP_ADD_W_IMM = 8'h79;
   localparam logic [7:0] OP_ADD_L_IMM = 8'h7A;
   localparam logic [3:0] OP_ADD_B_IMM = 4'h8;
   localparam logic [3:0] IMM_SUBOP    = 4'h1;

   localparam int unsigned CCR_H_BIT = 5;
   localparam int unsigned CCR_N_BIT = 3;
   localparam int unsigned CCR_Z_BIT = 2;
   localparam int unsigned CCR_V_BIT = 1;
   localparam int unsigned CCR_C_BIT = 0;

   typedef struct packed {
      logic                 recognized;
      logic [1:0]           size;
      logic [REG_IDX_W-1:0] dst_idx;
      logic                 dst_sel;
      logic                 src_imm;
      logic [REG_IDX_W-1:0] src_idx;
      logic                 src_sel;
      logic [DATA_W-1:0]    imm;
   } op_type;

endpackage

`default_nettype wire

// ===== rtl/rfaf_req_if.sv =====
// Instruction channel: valid/ready handshake carrying one instruction per item.
// Depends on rfaf_pkg for the field widths.
`default_nettype none

interface rfaf_req_if;
   import rfaf_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode_word;
   logic [DATA_W-1:0]   immediate_value;

   modport source (output valid, output opcode_word, output immediate_value, input ready);
   modport sink (input valid, input opcode_word, input immediate_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rfaf_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one result per item.
// Depends on rfaf_pkg for the field widths.
`default_nettype none

interface rfaf_rsp_if;
   import rfaf_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 recognized;
   logic [REG_IDX_W-1:0] dest_register;
   logic [DATA_W-1:0]    sum_value;
   logic [CCR_W-1:0]     ccr_after;

   modport source (output valid, output recognized, output dest_register, output sum_value,
                   output ccr_after, input ready);
   modport sink (input valid, input recognized, input dest_register, input sum_value,
                 input ccr_after, output ready);
endinterface

`default_nettype wire

// ===== rtl/rfaf_decode.sv =====
// Front end: accepts instruction items and classifies them into ADD operations.
// Depends on rfaf_pkg and rfaf_req_if; feeds rfaf_queue.
`default_nettype none

module rfaf_decode (
   rfaf_req_if.sink         req_chan,
   input  wire logic        push_ready,
   output logic             push_valid,
   output rfaf_pkg::op_type push_op
);
   import rfaf_pkg::*;

   logic [7:0] first_byte;
   logic [3:0] hi_nib;
   logic [3:0] lo_nib;
   op_type     op;

   assign first_byte = req_chan.opcode_word[15:8];
   assign hi_nib     = req_chan.opcode_word[7:4];
   assign lo_nib     = req_chan.opcode_word[3:0];

   always_comb begin
      op = '0;
      if (first_byte == OP_ADD_B_REG) begin
         op.recognized = 1'b1;
         op.size       = SIZE_BYTE;
         op.dst_idx    = lo_nib[2:0];
         op.dst_sel    = lo_nib[3];
         op.src_idx    = hi_nib[2:0];
         op.src_sel    = hi_nib[3];
      end else if (first_byte == OP_ADD_W_REG) begin
         op.recognized = 1'b1;
         op.size       = SIZE_WORD;
         op.dst_idx    = lo_nib[2:0];
         op.dst_sel    = lo_nib[3];
         op.src_idx    = hi_nib[2:0];
         op.src_sel    = hi_nib[3];
      end else if (first_byte == OP_ADD_L_REG && hi_nib[3]) begin
         op.recognized = 1'b1;
         op.size       = SIZE_LONG;
         op.dst_idx    = lo_nib[2:0];
         op.src_idx    = hi_nib[2:0];
      end else if (first_byte == OP_ADD_W_IMM && hi_nib == IMM_SUBOP) begin
         op.recognized = 1'b1;
         op.size       = SIZE_WORD;
         op.dst_idx    = lo_nib[2:0];
         op.dst_sel    = lo_nib[3];
         op.src_imm    = 1'b1;
         op.imm        = {16'h0000, req_chan.immediate_value[15:0]};
      end else if (first_byte == OP_ADD_L_IMM && hi_nib == IMM_SUBOP) begin
         op.recognized = 1'b1;
         op.size       = SIZE_LONG;
         op.dst_idx    = lo_nib[2:0];
         op.src_imm    = 1'b1;
         op.imm        = req_chan.immediate_value;
      end else if (first_byte[7:4] == OP_ADD_B_IMM) begin
         op.recognized = 1'b1;
         op.size       = SIZE_BYTE;
         op.dst_idx    = first_byte[2:0];
         op.dst_sel    = first_byte[3];
         op.src_imm    = 1'b1;
         op.imm        = {24'h000000, req_chan.opcode_word[7:0]};
      end
   end

   assign push_valid     = req_chan.valid;
   assign push_op        = op;
   assign req_chan.ready = push_ready;

endmodule

`default_nettype wire

// ===== rtl/rfaf_queue.sv =====
// Short queue of decoded operations between the front end and the execute stage.
// Depends on rfaf_pkg for the operation type.
`default_nettype none

module rfaf_queue #(
   parameter int unsigned Depth = rfaf_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire rfaf_pkg::op_type push_op,
   input  wire logic             pop,
   output logic                  head_valid,
   output rfaf_pkg::op_type      head_op
);
   import rfaf_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   op_type            entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_in;
   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;
   logic              push;

   assign push_ready = (count_ff != CntW'(Depth));
   assign push       = push_valid && push_ready;
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count exceeds its depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !pop)
      else $error("execute stage took an item from an empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on a lone push");
`endif

endmodule

`default_nettype wire

// ===== rtl/rfaf_execute.sv =====
// Back end: register file read, add with flags, write back and the result register.
// Depends on rfaf_pkg and rfaf_rsp_if; takes operations from rfaf_queue.
`default_nettype none

module rfaf_execute (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire rfaf_pkg::op_type head_op,
   output logic                  pop,
   rfaf_rsp_if.source            rsp_chan
);
   import rfaf_pkg::*;

   logic [DATA_W-1:0]    regfile_mem [REG_COUNT];
   logic [REG_COUNT-1:0] mem_valid_ff;
   logic [REG_COUNT-1:0] mem_valid_in;

   logic                 op_valid_ff;
   logic                 op_valid_in;
   op_type               op_ff;
   logic [DATA_W-1:0]    dst_data_ff;
   logic [DATA_W-1:0]    src_data_ff;
   logic [CCR_W-1:0]     ccr_ff;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 out_recognized_ff;
   logic [REG_IDX_W-1:0] out_dest_ff;
   logic [DATA_W-1:0]    out_sum_ff;
   logic [CCR_W-1:0]     out_ccr_ff;

   logic                 fire;
   logic                 load;
   logic                 wr_en;
   logic [DATA_W-1:0]    opnd_a;
   logic [DATA_W-1:0]    opnd_b;
   logic [DATA_W:0]      sum_full;
   logic [DATA_W-1:0]    result;
   logic [DATA_W-1:0]    merged;
   logic [DATA_W-1:0]    ovf_vec;
   logic [4:0]           top_bit;
   logic [4:0]           half_bit;
   logic                 carry;
   logic [CCR_W-1:0]     ccr_new;

   assign fire  = op_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign load  = !op_valid_ff || fire;
   assign pop   = load && head_valid;
   assign wr_en = fire && op_ff.recognized;

   always_comb begin
      case (op_ff.size)
         SIZE_BYTE: begin
            opnd_a = {24'h000000, op_ff.dst_sel ? dst_data_ff[7:0] : dst_data_ff[15:8]};
            if (op_ff.src_imm) begin
               opnd_b = {24'h000000, op_ff.imm[7:0]};
            end else begin
               opnd_b = {24'h000000, op_ff.src_sel ? src_data_ff[7:0] : src_data_ff[15:8]};
            end
         end
         SIZE_WORD: begin
            opnd_a = {16'h0000, op_ff.dst_sel ? dst_data_ff[31:16] : dst_data_ff[15:0]};
            if (op_ff.src_imm) begin
               opnd_b = {16'h0000, op_ff.imm[15:0]};
            end else begin
               opnd_b = {16'h0000, op_ff.src_sel ? src_data_ff[31:16] : src_data_ff[15:0]};
            end
         end
         default: begin
            opnd_a = dst_data_ff;
            opnd_b = op_ff.src_imm ? op_ff.imm : src_data_ff;
         end
      endcase
   end

   assign sum_full = {1'b0, opnd_a} + {1'b0, opnd_b};
   assign ovf_vec  = ~(opnd_a ^ opnd_b) & (opnd_a ^ sum_full[DATA_W-1:0]);

   always_comb begin
      case (op_ff.size)
         SIZE_BYTE: begin
            result   = {24'h000000, sum_full[7:0]};
            carry    = sum_full[8];
            top_bit  = 5'd7;
            half_bit = 5'd4;
            if (op_ff.dst_sel) begin
               merged = {dst_data_ff[31:8], sum_full[7:0]};
            end else begin
               merged = {dst_data_ff[31:16], sum_full[7:0], dst_data_ff[7:0]};
            end
         end
         SIZE_WORD: begin
            result   = {16'h0000, sum_full[15:0]};
            carry    = sum_full[16];
            top_bit  = 5'd15;
            half_bit = 5'd12;
            if (op_ff.dst_sel) begin
               merged = {sum_full[15:0], dst_data_ff[15:0]};
            end else begin
               merged = {dst_data_ff[31:16], sum_full[15:0]};
            end
         end
         default: begin
            result   = sum_full[DATA_W-1:0];
            carry    = sum_full[DATA_W];
            top_bit  = 5'd31;
            half_bit = 5'd28;
            merged   = sum_full[DATA_W-1:0];
         end
      endcase
   end

   // The half carry is the carry into the bit above the low nibble group.
   always_comb begin
      ccr_new            = ccr_ff;
      ccr_new[CCR_H_BIT] = sum_full[half_bit] ^ opnd_a[half_bit] ^ opnd_b[half_bit];
      ccr_new[CCR_N_BIT] = sum_full[top_bit];
      ccr_new[CCR_Z_BIT] = (result == '0);
      ccr_new[CCR_V_BIT] = ovf_vec[top_bit];
      ccr_new[CCR_C_BIT] = carry;
   end

   always_comb begin
      op_valid_in  = op_valid_ff;
      out_valid_in = out_valid_ff;
      mem_valid_in = mem_valid_ff;
      if (load) begin
         op_valid_in = head_valid;
      end
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (wr_en) begin
         mem_valid_in[op_ff.dst_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mem_valid_ff <= '0;
         ccr_ff       <= '0;
      end else begin
         op_valid_ff  <= op_valid_in;
         out_valid_ff <= out_valid_in;
         mem_valid_ff <= mem_valid_in;
         if (wr_en) begin
            ccr_ff <= ccr_new;
         end
      end
   end

   // A write in the same cycle as a read is forwarded to the read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         regfile_mem[op_ff.dst_idx] <= merged;
      end
      if (load) begin
         op_ff <= head_op;
      end
      if (pop) begin
         if (wr_en && op_ff.dst_idx == head_op.dst_idx) begin
            dst_data_ff <= merged;
         end else if (mem_valid_ff[head_op.dst_idx]) begin
            dst_data_ff <= regfile_mem[head_op.dst_idx];
         end else begin
            dst_data_ff <= '0;
         end
         if (wr_en && op_ff.dst_idx == head_op.src_idx) begin
            src_data_ff <= merged;
         end else if (mem_valid_ff[head_op.src_idx]) begin
            src_data_ff <= regfile_mem[head_op.src_idx];
         end else begin
            src_data_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_recognized_ff <= op_ff.recognized;
         out_dest_ff       <= op_ff.recognized ? op_ff.dst_idx : '0;
         out_sum_ff        <= op_ff.recognized ? result : '0;
         out_ccr_ff        <= op_ff.recognized ? ccr_new : ccr_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.recognized    = out_recognized_ff;
   assign rsp_chan.dest_register = out_dest_ff;
   assign rsp_chan.sum_value     = out_sum_ff;
   assign rsp_chan.ccr_after     = out_ccr_ff;

`ifndef SYNTHESIS
   a_ccr_hold: assert property (@(posedge clock) disable iff (reset)
      (!fire || !op_ff.recognized) |=> $stable(ccr_ff))
      else $error("condition codes changed without an executed ADD");
   a_ccr_report: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_chan.valid && rsp_chan.ccr_after == ccr_ff))
      else $error("reported condition codes differ from the architectural ones");
   a_valid_clear: assert property (@(posedge clock)
      reset |=> (mem_valid_ff == '0))
      else $error("register valid bits not cleared by reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/register_file_add_with_flags.sv =====
// Top level of the register file ADD unit with condition codes.
// Depends on rfaf_pkg, rfaf_req_if, rfaf_rsp_if, rfaf_decode, rfaf_queue and rfaf_execute.
//
//   Channel   Direction  Handshake         Payload
//   req_chan  in         valid/ready       opcode_word, immediate_value
//   rsp_chan  out        valid/ready       recognized, dest_register, sum_value, ccr_after
//
// One item is accepted per cycle and one result leaves per cycle when nothing stalls.
// An accepted item is held in the queue, then registered with its register file read data;
// the add, flags and write back end as the result is taken into the result register.
// Reset is synchronous and clears the queue, the pipeline, the CCR and the register valid bits.
// A stalled result holds the execute stage; the queue then fills and drops req_chan.ready.
`default_nettype none

module register_file_add_with_flags #(
   parameter int unsigned QueueDepth = rfaf_pkg::QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rfaf_req_if.sink   req_chan,
   rfaf_rsp_if.source rsp_chan
);
   import rfaf_pkg::*;

   logic   push_valid;
   logic   push_ready;
   op_type push_op;
   logic   pop;
   logic   head_valid;
   op_type head_op;

   rfaf_decode u_decode (
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   rfaf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   rfaf_execute u_execute (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== bench/register_file_add_with_flags_tb.sv =====
// Testbench for the register file ADD unit with condition codes.
// Drives instructions through the request channel, predicts each result and checks it.
// Depends on rfaf_pkg, rfaf_req_if, rfaf_rsp_if and register_file_add_with_flags.
`default_nettype none

module register_file_add_with_flags_tb;
   import rfaf_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 426;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES  = 60;
   localparam int unsigned IDLE_PERCENT = 17;

   typedef struct packed {
      logic                recognized;
      logic [REG_IDX_W-1:0] dest_register;
      logic [DATA_W-1:0]    sum_value;
      logic [CCR_W-1:0]     ccr_after;
   } add_result_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode_word;
      logic [DATA_W-1:0]   immediate_value;
      logic                wait_for_drain;
   } add_instr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rfaf_req_if req_chan ();
   rfaf_rsp_if rsp_chan ();

   register_file_add_with_flags dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   logic [DATA_W-1:0] model_regs [REG_COUNT];
   logic [CCR_W-1:0]  model_ccr;

   add_instr_type  pending_instrs [$];
   add_result_type expected_results [$];
   add_instr_type  next_instr;
   add_result_type oldest_result;

   logic item_taken = 1'b0;
   int unsigned instrs_issued = 0;
   int unsigned results_seen = 0;
   int unsigned error_count = 0;
   int unsigned hold_left = 0;
   logic hold_done = 1'b0;
   int unsigned stall_cycles = 0;

   function automatic logic [DATA_W-1:0] add_and_set_flags(logic [DATA_W-1:0] a,
                                                          logic [DATA_W-1:0] b,
                                                          int unsigned bits);
      logic [DATA_W:0]   full;
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] top;
      logic [DATA_W-1:0] hmask;
      logic [DATA_W-1:0] hsum;
      full  = {1'b0, a} + {1'b0, b};
      sum   = (bits == DATA_W) ? full[DATA_W-1:0] : full[DATA_W-1:0] & ((32'd1 << bits) - 1);
      top   = 32'd1 << (bits - 1);
      hmask = (32'd1 << (bits - 4)) - 1;
      hsum  = (a & hmask) + (b & hmask);
      model_ccr[CCR_H_BIT] = hsum[bits-4];
      model_ccr[CCR_N_BIT] = |(sum & top);
      model_ccr[CCR_Z_BIT] = (sum == '0);
      model_ccr[CCR_V_BIT] = |(~(a ^ b) & (a ^ sum) & top);
      model_ccr[CCR_C_BIT] = full[bits];
      return sum;
   endfunction

   function automatic logic [DATA_W-1:0] byte_view(logic [3:0] sel);
      return sel[3] ? {24'h0, model_regs[sel[2:0]][7:0]} : {24'h0, model_regs[sel[2:0]][15:8]};
   endfunction

   function automatic void write_byte_view(logic [3:0] sel, logic [7:0] value);
      if (sel[3]) begin
         model_regs[sel[2:0]][7:0] = value;
      end else begin
         model_regs[sel[2:0]][15:8] = value;
      end
   endfunction

   function automatic logic [DATA_W-1:0] word_view(logic [3:0] sel);
      return sel[3] ? {16'h0, model_regs[sel[2:0]][31:16]} : {16'h0, model_regs[sel[2:0]][15:0]};
   endfunction

   function automatic void write_word_view(logic [3:0] sel, logic [15:0] value);
      if (sel[3]) begin
         model_regs[sel[2:0]][31:16] = value;
      end else begin
         model_regs[sel[2:0]][15:0] = value;
      end
   endfunction

   function automatic add_result_type execute_add(logic [OPCODE_W-1:0] opcode,
                                                  logic [DATA_W-1:0] imm);
      add_result_type r;
      logic [7:0]     first;
      logic [3:0]     hi;
      logic [3:0]     lo;
      first = opcode[15:8];
      hi    = opcode[7:4];
      lo    = opcode[3:0];
      r     = '0;
      r.recognized    = 1'b1;
      r.dest_register = lo[2:0];
      if (first == OP_ADD_B_REG) begin
         r.sum_value = add_and_set_flags(byte_view(lo), byte_view(hi), 8);
         write_byte_view(lo, r.sum_value[7:0]);
      end else if (first == OP_ADD_W_REG) begin
         r.sum_value = add_and_set_flags(word_view(lo), word_view(hi), 16);
         write_word_view(lo, r.sum_value[15:0]);
      end else if (first == OP_ADD_L_REG && hi[3]) begin
         r.sum_value = add_and_set_flags(model_regs[lo[2:0]], model_regs[hi[2:0]], 32);
         model_regs[lo[2:0]] = r.sum_value;
      end else if (first == OP_ADD_W_IMM && hi == IMM_SUBOP) begin
         r.sum_value = add_and_set_flags(word_view(lo), {16'h0, imm[15:0]}, 16);
         write_word_view(lo, r.sum_value[15:0]);
      end else if (first == OP_ADD_L_IMM && hi == IMM_SUBOP) begin
         r.sum_value = add_and_set_flags(model_regs[lo[2:0]], imm, 32);
         model_regs[lo[2:0]] = r.sum_value;
      end else if (first[7:4] == OP_ADD_B_IMM) begin
         r.dest_register = first[2:0];
         r.sum_value = add_and_set_flags(byte_view(first[3:0]), {24'h0, opcode[7:0]}, 8);
         write_byte_view(first[3:0], r.sum_value[7:0]);
      end else begin
         r.recognized    = 1'b0;
         r.dest_register = '0;
      end
      r.ccr_after = model_ccr;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'h0000_FFFF;
         5: return 32'h0000_7FFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic add_instr_type random_instr();
      add_instr_type     item;
      int unsigned       roll;
      logic [7:0]        regs;
      logic [DATA_W-1:0] operand;
      roll    = $urandom_range(0, 99);
      regs    = 8'($urandom_range(0, 255));
      operand = pick_operand();
      item.immediate_value = pick_operand();
      item.wait_for_drain  = 1'b0;
      if (roll < 14) begin
         item.opcode_word = {OP_ADD_B_REG, regs};
      end else if (roll < 28) begin
         item.opcode_word = {OP_ADD_W_REG, regs};
      end else if (roll < 40) begin
         item.opcode_word = {OP_ADD_L_REG, 1'b1, regs[6:0]};
      end else if (roll < 54) begin
         item.opcode_word = {OP_ADD_W_IMM, IMM_SUBOP, regs[3:0]};
      end else if (roll < 68) begin
         item.opcode_word = {OP_ADD_L_IMM, IMM_SUBOP, regs[3:0]};
      end else if (roll < 88) begin
         item.opcode_word = {OP_ADD_B_IMM, regs[3:0], operand[7:0]};
      end else begin
         item.opcode_word = OPCODE_W'($urandom_range(0, 65535));
      end
      return item;
   endfunction

   task automatic queue_instr(logic [OPCODE_W-1:0] opcode, logic [DATA_W-1:0] imm);
      add_instr_type item;
      item.opcode_word     = opcode;
      item.immediate_value = imm;
      item.wait_for_drain  = 1'b0;
      pending_instrs.push_back(item);
   endtask

   task automatic report_mismatch(string field, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      item_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         expected_results.push_back(execute_add(req_chan.opcode_word,
                                                req_chan.immediate_value));
         instrs_issued++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual 0x%0h", $time,
                     rsp_chan.sum_value);
            error_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_chan.recognized !== oldest_result.recognized)
               report_mismatch("recognized", oldest_result.recognized, rsp_chan.recognized);
            if (rsp_chan.dest_register !== oldest_result.dest_register)
               report_mismatch("dest_register", oldest_result.dest_register,
                               rsp_chan.dest_register);
            if (rsp_chan.sum_value !== oldest_result.sum_value)
               report_mismatch("sum_value", oldest_result.sum_value, rsp_chan.sum_value);
            if (rsp_chan.ccr_after !== oldest_result.ccr_after)
               report_mismatch("ccr_after", oldest_result.ccr_after, rsp_chan.ccr_after);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || item_taken) begin
         if (pending_instrs.size() != 0
             && !(pending_instrs[0].wait_for_drain && expected_results.size() != 0)
             && !(hold_left == 0 && !(instrs_issued >= 200 && instrs_issued < 300)
                  && $urandom_range(0, 99) < IDLE_PERCENT)) begin
            next_instr = pending_instrs.pop_front();
            req_chan.valid           <= 1'b1;
            req_chan.opcode_word     <= next_instr.opcode_word;
            req_chan.immediate_value <= next_instr.immediate_value;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 120) begin
         hold_left      <= HOLD_CYCLES;
         hold_done      <= 1'b1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= (results_seen >= 200 && results_seen < 300)
                           || $urandom_range(0, 99) >= IDLE_PERCENT;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("register_file_add_with_flags_tb: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      add_instr_type item;
      req_chan.valid           = 1'b0;
      req_chan.opcode_word     = '0;
      req_chan.immediate_value = '0;
      rsp_chan.ready           = 1'b0;
      for (int i = 0; i < REG_COUNT; i++) model_regs[i] = '0;
      model_ccr = '0;

      // Byte immediates and registers: zero, negative, carry, half carry and overflow.
      queue_instr({OP_ADD_B_IMM, 4'h0, 8'h00}, '0);
      queue_instr({OP_ADD_B_IMM, 4'h8, 8'hFF}, '1);
      queue_instr({OP_ADD_B_IMM, 4'h8, 8'h01}, '0);
      queue_instr({OP_ADD_B_IMM, 4'h1, 8'h7F}, '0);
      queue_instr({OP_ADD_B_IMM, 4'h1, 8'h01}, '0);
      queue_instr({OP_ADD_B_REG, 4'h1, 4'h0}, '1);
      // Word immediates ignore the upper half of the immediate.
      queue_instr({OP_ADD_W_IMM, IMM_SUBOP, 4'hA}, 32'hABCD_FFFF);
      queue_instr({OP_ADD_W_IMM, IMM_SUBOP, 4'hA}, 32'hFFFF_0001);
      queue_instr({OP_ADD_W_IMM, IMM_SUBOP, 4'h3}, 32'h0000_7FFF);
      queue_instr({OP_ADD_W_IMM, IMM_SUBOP, 4'h3}, 32'h0000_0001);
      queue_instr({OP_ADD_W_REG, 4'h3, 4'hA}, '0);
      queue_instr({OP_ADD_W_REG, 4'hA, 4'h3}, '0);
      // Long forms, including a destination nibble with bit 3 set.
      queue_instr({OP_ADD_L_IMM, IMM_SUBOP, 4'h4}, 32'hFFFF_FFFF);
      queue_instr({OP_ADD_L_IMM, IMM_SUBOP, 4'hC}, 32'h0000_0001);
      queue_instr({OP_ADD_L_IMM, IMM_SUBOP, 4'h5}, 32'h7FFF_FFFF);
      queue_instr({OP_ADD_L_REG, 4'hD, 4'h5}, '0);
      queue_instr({OP_ADD_L_REG, 4'hD, 4'hF}, '0);
      // Opcodes that are not an ADD form leave the state alone; the last two are byte ADDs on R7L.
      queue_instr({OP_ADD_L_REG, 4'h5, 4'h5}, '0);
      queue_instr({OP_ADD_W_IMM, 4'h2, 4'h0}, '0);
      queue_instr({OP_ADD_L_IMM, 4'h0, 4'h0}, '1);
      queue_instr(16'h0000, '0);
      queue_instr(16'hFFFF, '1);
      queue_instr({OP_ADD_B_IMM, 4'hF, 8'h80}, '0);
      queue_instr({OP_ADD_B_REG, 4'hF, 4'hF}, '0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         item = random_instr();
         item.wait_for_drain = (i == 300);
         pending_instrs.push_back(item);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_instrs.size() != 0 || req_chan.valid) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (error_count == 0) begin
         $display("register_file_add_with_flags_tb: PASS");
      end else begin
         $display("register_file_add_with_flags_tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/rfaf_pkg.sv
rtl/rfaf_req_if.sv
rtl/rfaf_rsp_if.sv
rtl/rfaf_decode.sv
rtl/rfaf_queue.sv
rtl/rfaf_execute.sv
rtl/register_file_add_with_flags.sv
bench/register_file_add_with_flags_tb.sv
